// File: hdl/pbs_pkg.sv
package pbs_pkg;

    // Field widths
    localparam int TIME_W = 32;
    localparam int DUR_W  = 16;
    localparam int CAP_W  = 7;

    // Defaults
    localparam int              DEFAULT_QUEUE_DEPTH = 64;
    localparam logic [CAP_W-1:0] CAP_RESET          = 7'd64;

    // Input beat: one packet
    typedef struct packed {
        logic [TIME_W-1:0] arrival_time;
        logic [DUR_W-1:0]  duration;
    } t_in;

    // Output beat: one scheduling decision
    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic              dropped;
    } t_out;

    // Controls broadcast to every cell of the chain
    typedef struct packed {
        logic pop;   // shift every entry one place toward the head
        logic push;  // load the new finish time into the cell at the fill point
    } t_cell_ctl;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

endpackage

// File: hdl/pbs_cell.sv
module pbs_cell #(
    parameter int IDX_W = 6,
    parameter int INDEX = 0
) (
    input  logic                       i_clk,
    input  pbs_pkg::t_cell_ctl         i_ctl,
    input  logic [IDX_W-1:0]           i_wr_index,
    input  logic [pbs_pkg::TIME_W-1:0] i_push_data,
    input  logic [pbs_pkg::TIME_W-1:0] i_next_data,
    output logic [pbs_pkg::TIME_W-1:0] o_data
);
    import pbs_pkg::*;

    logic [TIME_W-1:0] r_data;
    logic [TIME_W-1:0] n_data;

    // Take the neighbor's entry on a pop, the new entry when this is the fill point
    always_comb begin
        n_data = r_data;
        if (i_ctl.pop) begin
            n_data = i_next_data;
        end else if (i_ctl.push && (i_wr_index == IDX_W'(INDEX))) begin
            n_data = i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: hdl/packet_buffer_scheduler.sv
// Channel  Direction  Handshake               Payload
// in       sink       i_in_valid / o_in_stall  i_in_data  (pbs_pkg::t_in)
// out      source     o_out_valid / i_out_stall o_out_data (pbs_pkg::t_out)
// cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_data (buffer_capacity)
//
// A packet is accepted in ST_IDLE and then scanned in ST_SCAN, which removes each finish time it has passed:
// the chain of cells retires one entry per cycle, compared at cell 0.
// Reset (synchronous, i_rst_n low) empties the queue, idles the sequencer,
// drops any pending output beat and sets the capacity to 64. No clearing pass.
// A stalled output beat holds in its register; the next packet is still taken
// and scanned, and waits only for the register to free before it finishes.
module packet_buffer_scheduler #(
    parameter int QUEUE_DEPTH = pbs_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  pbs_pkg::t_in              i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output pbs_pkg::t_out             o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [pbs_pkg::CAP_W-1:0] i_cfg_data
);
    import pbs_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CAP_W-1:0]  r_cap;
    logic [TIME_W-1:0] r_arrival;
    logic [DUR_W-1:0]  r_duration;
    logic [TIME_W-1:0] r_newest;
    logic              r_out_valid;
    t_out              r_out_data;

    logic [TIME_W-1:0] w_cell [QUEUE_DEPTH];
    t_cell_ctl         w_ctl;
    logic              w_accept;
    logic              w_head_done;
    logic              w_out_free;
    logic              w_finish;
    logic              w_drop;
    logic [TIME_W-1:0] w_start;
    logic [TIME_W-1:0] w_finish_time;

    // Configuration: always ready; to be written only while idle, which the block does not enforce
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_data;
        end
    end

    // Decision terms
    assign w_accept      = i_in_valid && !o_in_stall;
    assign w_head_done   = (r_count != '0) && (w_cell[0] <= r_arrival);
    assign w_out_free    = !r_out_valid || !i_out_stall;
    assign w_drop        = (CMP_W'(r_count) >= CMP_W'(r_cap))
                           || (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_start       = (r_count == '0) ? r_arrival : r_newest;
    assign w_finish_time = w_start + TIME_W'(r_duration);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (!w_head_done && w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_ctl      = '0;
        w_finish   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            ST_SCAN: begin
                w_ctl.pop  = w_head_done;
                w_finish   = !w_head_done && w_out_free;
                w_ctl.push = w_finish && !w_drop;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // Track occupancy: one pop or one push per cycle
    always_comb begin
        n_count = r_count;
        if (w_ctl.pop) begin
            n_count = r_count - CNT_W'(1);
        end else if (w_ctl.push) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the packet, the newest finish time and the output beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_arrival  <= i_in_data.arrival_time;
            r_duration <= i_in_data.duration;
        end
        if (w_ctl.push) begin
            r_newest <= w_finish_time;
        end
        if (w_finish) begin
            r_out_data.start_time <= w_drop ? '0 : w_start;
            r_out_data.dropped    <= w_drop;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Chain of finish-time cells, head at cell 0
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic [TIME_W-1:0] w_next;
        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_cell[g+1];
        end
        pbs_cell #(
            .IDX_W (IDX_W),
            .INDEX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_wr_index  (r_count[IDX_W-1:0]),
            .i_push_data (w_finish_time),
            .i_next_data (w_next),
            .o_data      (w_cell[g])
        );
    end

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.dropped) |-> (o_out_data.start_time == '0))
        else $error("dropped beat carries a start time");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.push |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("push did not grow occupancy");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.pop |-> (r_count != '0))
        else $error("pop from empty queue");

endmodule
